@@ rtl/core/qrs_pkg.sv @@
// Shared types and constants for the quadratic root solver.
// No dependencies; used by the top, front, back and testbench files.
package qrs_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  typedef enum logic [1:0] {
    KIND_REAL   = 2'd0,
    KIND_CPLX   = 2'd1,
    KIND_DOUBLE = 2'd2,
    KIND_LEADZ  = 2'd3
  } qrs_kind_t;

  // Coefficient signs, zero a, and the coarse class of the discriminant.
  typedef struct packed {
    logic an;
    logic bn;
    logic cn;
    logic dneg;
    logic azero;
  } qrs_flags_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] lead_coeff;
    logic signed [WORD_BITS-1:0] lin_coeff;
    logic signed [WORD_BITS-1:0] const_coeff;
  } qrs_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] root0_re;
    logic signed [WORD_BITS-1:0] root0_im;
    logic signed [WORD_BITS-1:0] root1_re;
    logic signed [WORD_BITS-1:0] root1_im;
    qrs_kind_t                   root_kind;
    logic                        saturated;
  } qrs_out_t;

endpackage

@@ rtl/core/quadratic_root_solver.sv @@
// Top level of the quadratic root solver: front end, square root, operand
// selection, two dividers and the output stage. Uses qrs_pkg throughout.
//
// Usage: present a, b, c (signed Q16.16) on in_data with in_valid; the item
// is taken at a clock edge where in_valid is high and in_stall is low. The
// roots, their kind code and the saturation flag come out on out_data with
// out_valid, and are taken when out_stall is low.
// Pipeline: three front stages (magnitudes, products, discriminant),
// WORD_BITS+1 square root stages, one operand stage, WORD_BITS+FRAC_BITS+3
// divider stages including rounding, and the output register. Throughput is
// one item per cycle while out_stall does not hold the pipe; the bit-per-stage
// square root and dividers set the depth, not the rate.
// The whole pipeline advances together. While out_valid is high and
// out_stall is high every stage holds, and in_stall is raised; nothing is
// dropped or repeated. Synchronous reset clears all valid bits, so the pipe
// comes up empty and ready at the first cycle after reset.
module quadratic_root_solver #(
  parameter int WORD_BITS = qrs_pkg::WORD_BITS,
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  qrs_pkg::qrs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output qrs_pkg::qrs_out_t out_data
);
  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int RW   = 2 * W + 2;
  localparam int SW   = RW / 2;
  localparam int NB   = W + 2;
  localparam int NW   = NB + F;
  localparam int FLW  = $bits(qrs_pkg::qrs_flags_t);
  localparam int SBW  = 3 * W + FLW;

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Front end
  logic                fr_v;
  logic [W-1:0]        fr_a, fr_b, fr_c;
  qrs_pkg::qrs_flags_t fr_f;
  logic [RW-1:0]       fr_d;

  qrs_front #(.WORD_BITS(W)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_valid),
    .a     (W'(in_data.lead_coeff)),
    .b     (W'(in_data.lin_coeff)),
    .c     (W'(in_data.const_coeff)),
    .out_v (fr_v),
    .a_mag (fr_a),
    .b_mag (fr_b),
    .c_mag (fr_c),
    .flags (fr_f),
    .dmag  (fr_d)
  );

  // Square root of the discriminant magnitude
  logic                sq_v;
  logic [SW-1:0]       sq_s;
  logic [SBW-1:0]      sq_sb;
  logic [W-1:0]        sq_a, sq_b, sq_c;
  qrs_pkg::qrs_flags_t sq_f;

  qrs_isqrt #(.RAD_BITS(RW), .SB_BITS(SBW)) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (fr_v),
    .rad    (fr_d),
    .in_sb  ({fr_a, fr_b, fr_c, fr_f}),
    .out_v  (sq_v),
    .root   (sq_s),
    .out_sb (sq_sb)
  );

  assign {sq_a, sq_b, sq_c, sq_f} = sq_sb;

  // Operand selection for the two dividers
  logic               real_c, nneg, reneg, sx_nxt, sy_nxt;
  logic [NB-1:0]      n_sum, twoa;
  qrs_pkg::qrs_kind_t kind_nxt;
  logic               md_v_r, md_sx_r, md_sy_r;
  qrs_pkg::qrs_kind_t md_kind_r;
  logic [NW-1:0]      md_nx_r, md_ny_r;
  logic [NB-1:0]      md_dx_r, md_dy_r;

  assign n_sum  = {2'b00, sq_b} + {1'b0, sq_s};
  assign twoa   = {1'b0, sq_a, 1'b0};
  assign real_c = !sq_f.azero && !sq_f.dneg && (sq_s != '0);
  assign nneg   = !sq_f.bn && (sq_b != '0);
  assign reneg  = (sq_b != '0) && (sq_f.bn == sq_f.an);
  assign sx_nxt = real_c ? (nneg != sq_f.an) : reneg;
  assign sy_nxt = real_c ? ((sq_c != '0) && (sq_f.cn != nneg)) : sq_f.an;

  always_comb begin
    if (sq_f.azero) begin
      kind_nxt = qrs_pkg::KIND_LEADZ;
    end else if (sq_f.dneg) begin
      kind_nxt = qrs_pkg::KIND_CPLX;
    end else if (sq_s == '0) begin
      kind_nxt = qrs_pkg::KIND_DOUBLE;
    end else begin
      kind_nxt = qrs_pkg::KIND_REAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_v_r <= 1'b0;
    end else if (en) begin
      md_v_r <= sq_v;
    end
    if (en) begin
      md_kind_r <= kind_nxt;
      md_sx_r   <= sx_nxt;
      md_sy_r   <= sy_nxt;
      md_nx_r   <= {(real_c ? n_sum : NB'(sq_b)), {F{1'b0}}};
      md_dx_r   <= twoa;
      md_ny_r   <= {(real_c ? {1'b0, sq_c, 1'b0} : NB'(sq_s)), {F{1'b0}}};
      md_dy_r   <= real_c ? n_sum : twoa;
    end
  end

  // Dividers
  logic          dx_v, dy_v, dx_sb;
  logic [2:0]    dy_sb;
  logic [NW:0]   qx, qy;

  qrs_divider #(.NUM_BITS(NW), .DEN_BITS(NB), .SB_BITS(1)) u_div_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (md_v_r),
    .num    (md_nx_r),
    .den    (md_dx_r),
    .in_sb  (md_sx_r),
    .out_v  (dx_v),
    .quot   (qx),
    .out_sb (dx_sb)
  );

  qrs_divider #(.NUM_BITS(NW), .DEN_BITS(NB), .SB_BITS(3)) u_div_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (md_v_r),
    .num    (md_ny_r),
    .den    (md_dy_r),
    .in_sb  ({md_kind_r, md_sy_r}),
    .out_v  (dy_v),
    .quot   (qy),
    .out_sb (dy_sb)
  );

  qrs_back #(.WORD_BITS(W), .Q_BITS(NW + 1)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (dx_v & dy_v),
    .qx       (qx),
    .qy       (qy),
    .kind     (qrs_pkg::qrs_kind_t'(dy_sb[2:1])),
    .sx       (dx_sb),
    .sy       (dy_sb[0]),
    .out_v    (out_valid),
    .out_item (out_data)
  );

  // A zero leading coefficient yields all-zero roots and no saturation.
  a_leadz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.root_kind == qrs_pkg::KIND_LEADZ |->
      out_data.root0_re == '0 && out_data.root0_im == '0 &&
      out_data.root1_re == '0 && out_data.root1_im == '0 && !out_data.saturated)
    else $error("leading-zero item carries nonzero roots");

  // Real and double roots have no imaginary parts.
  a_real_im: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.root_kind == qrs_pkg::KIND_REAL ||
                  out_data.root_kind == qrs_pkg::KIND_DOUBLE) |->
      out_data.root0_im == '0 && out_data.root1_im == '0)
    else $error("real roots carry an imaginary part");

  // An unclipped complex pair is conjugate with a shared real part.
  a_conj: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.root_kind == qrs_pkg::KIND_CPLX && !out_data.saturated |->
      out_data.root1_im == -out_data.root0_im && out_data.root1_re == out_data.root0_re)
    else $error("complex pair is not conjugate");

  // The two dividers stay in lockstep.
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n) dx_v == dy_v)
    else $error("divider valid bits diverged");
endmodule

@@ rtl/core/qrs_front.sv @@
// Front end: coefficient magnitudes, the two products and the discriminant.
// Three register stages; uses qrs_pkg for the flag struct.
module qrs_front #(
  parameter int WORD_BITS = qrs_pkg::WORD_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_v,
  input  logic [WORD_BITS-1:0]     a,
  input  logic [WORD_BITS-1:0]     b,
  input  logic [WORD_BITS-1:0]     c,
  output logic                     out_v,
  output logic [WORD_BITS-1:0]     a_mag,
  output logic [WORD_BITS-1:0]     b_mag,
  output logic [WORD_BITS-1:0]     c_mag,
  output qrs_pkg::qrs_flags_t      flags,
  output logic [2*WORD_BITS+1:0]   dmag
);
  localparam int W  = WORD_BITS;
  localparam int DW = 2 * WORD_BITS + 2;

  logic                s1_v_r, s2_v_r, s3_v_r;
  logic [W-1:0]        s1_a_r, s1_b_r, s1_c_r, s2_a_r, s2_b_r, s2_c_r, s3_a_r, s3_b_r, s3_c_r;
  qrs_pkg::qrs_flags_t s1_f_r, s2_f_r, s3_f_r, s1_f_nxt, s3_f_nxt;
  logic [2*W-1:0]      s2_bb_r, s2_ac_r;
  logic [DW-1:0]       s3_d_r, s3_d_nxt, bbx, ac4;

  always_comb begin
    s1_f_nxt.an    = a[W-1];
    s1_f_nxt.bn    = b[W-1];
    s1_f_nxt.cn    = c[W-1];
    s1_f_nxt.dneg  = 1'b0;
    s1_f_nxt.azero = (a == '0);
  end

  assign bbx = {2'b00, s2_bb_r};
  assign ac4 = {s2_ac_r, 2'b00};

  always_comb begin
    s3_f_nxt = s2_f_r;
    if (s2_f_r.an != s2_f_r.cn) begin
      s3_d_nxt = bbx + ac4;
    end else if (bbx >= ac4) begin
      s3_d_nxt = bbx - ac4;
    end else begin
      s3_d_nxt      = ac4 - bbx;
      s3_f_nxt.dneg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
    if (en) begin
      s1_a_r  <= a[W-1] ? (~a + 1'b1) : a;
      s1_b_r  <= b[W-1] ? (~b + 1'b1) : b;
      s1_c_r  <= c[W-1] ? (~c + 1'b1) : c;
      s1_f_r  <= s1_f_nxt;
      s2_bb_r <= s1_b_r * s1_b_r;
      s2_ac_r <= s1_a_r * s1_c_r;
      s2_a_r  <= s1_a_r;
      s2_b_r  <= s1_b_r;
      s2_c_r  <= s1_c_r;
      s2_f_r  <= s1_f_r;
      s3_d_r  <= s3_d_nxt;
      s3_f_r  <= s3_f_nxt;
      s3_a_r  <= s2_a_r;
      s3_b_r  <= s2_b_r;
      s3_c_r  <= s2_c_r;
    end
  end

  assign out_v = s3_v_r;
  assign a_mag = s3_a_r;
  assign b_mag = s3_b_r;
  assign c_mag = s3_c_r;
  assign flags = s3_f_r;
  assign dmag  = s3_d_r;
endmodule

@@ rtl/core/qrs_isqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Carries an opaque sideband word alongside; no package dependencies.
module qrs_isqrt #(
  parameter int RAD_BITS = 66,
  parameter int SB_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_v,
  input  logic [RAD_BITS-1:0]   rad,
  input  logic [SB_BITS-1:0]    in_sb,
  output logic                  out_v,
  output logic [RAD_BITS/2-1:0] root,
  output logic [SB_BITS-1:0]    out_sb
);
  localparam int SW = RAD_BITS / 2;

  logic              v_r    [SW];
  logic [SW-1:0]     root_r [SW];
  logic [SW+1:0]     rem_r  [SW];
  logic [RAD_BITS-1:0] rad_r [SW];
  logic [SB_BITS-1:0] sb_r  [SW];

  for (genvar i = 0; i < SW; i++) begin : g_stage
    logic                v_p;
    logic [SW-1:0]       root_p;
    logic [SW+1:0]       rem_p;
    logic [RAD_BITS-1:0] rad_p;
    logic [SB_BITS-1:0]  sb_p;
    logic [SW+3:0]       t, trial;
    logic                ge;

    if (i == 0) begin : g_first
      assign v_p    = in_v;
      assign root_p = '0;
      assign rem_p  = '0;
      assign rad_p  = rad;
      assign sb_p   = in_sb;
    end else begin : g_next
      assign v_p    = v_r[i-1];
      assign root_p = root_r[i-1];
      assign rem_p  = rem_r[i-1];
      assign rad_p  = rad_r[i-1];
      assign sb_p   = sb_r[i-1];
    end

    assign t     = {rem_p, rad_p[RAD_BITS-1 -: 2]};
    assign trial = {2'b00, root_p, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_p;
      end
      if (en) begin
        rem_r[i]  <= ge ? (SW+2)'(t - trial) : t[SW+1:0];
        root_r[i] <= {root_p[SW-2:0], ge};
        rad_r[i]  <= {rad_p[RAD_BITS-3:0], 2'b00};
        sb_r[i]   <= sb_p;
      end
    end
  end

  assign out_v  = v_r[SW-1];
  assign root   = root_r[SW-1];
  assign out_sb = sb_r[SW-1];
endmodule

@@ rtl/core/qrs_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, then a rounding
// stage (nearest, ties away from zero). No package dependencies.
module qrs_divider #(
  parameter int NUM_BITS = 50,
  parameter int DEN_BITS = 34,
  parameter int SB_BITS  = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  input  logic [SB_BITS-1:0]  in_sb,
  output logic                out_v,
  output logic [NUM_BITS:0]   quot,
  output logic [SB_BITS-1:0]  out_sb
);
  localparam int NW = NUM_BITS;
  localparam int DW = DEN_BITS;

  logic              v_r   [NW];
  logic [NW-1:0]     q_r   [NW];
  logic [NW-1:0]     num_r [NW];
  logic [DW-1:0]     rem_r [NW];
  logic [DW-1:0]     den_r [NW];
  logic [SB_BITS-1:0] sb_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic               v_p;
    logic [NW-1:0]      q_p, num_p;
    logic [DW-1:0]      rem_p, den_p;
    logic [SB_BITS-1:0] sb_p;
    logic [DW:0]        t, dx;
    logic               ge;

    if (i == 0) begin : g_first
      assign v_p   = in_v;
      assign q_p   = '0;
      assign num_p = num;
      assign rem_p = '0;
      assign den_p = den;
      assign sb_p  = in_sb;
    end else begin : g_next
      assign v_p   = v_r[i-1];
      assign q_p   = q_r[i-1];
      assign num_p = num_r[i-1];
      assign rem_p = rem_r[i-1];
      assign den_p = den_r[i-1];
      assign sb_p  = sb_r[i-1];
    end

    assign t  = {rem_p, num_p[NW-1]};
    assign dx = {1'b0, den_p};
    assign ge = (t >= dx);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_p;
      end
      if (en) begin
        rem_r[i] <= ge ? DW'(t - dx) : t[DW-1:0];
        q_r[i]   <= {q_p[NW-2:0], ge};
        num_r[i] <= {num_p[NW-2:0], 1'b0};
        den_r[i] <= den_p;
        sb_r[i]  <= sb_p;
      end
    end
  end

  logic               rv_r, rnd;
  logic [NW:0]        quot_r;
  logic [SB_BITS-1:0] rsb_r;

  // Round up when twice the remainder reaches the divisor.
  assign rnd = ({rem_r[NW-1], 1'b0} >= {1'b0, den_r[NW-1]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else if (en) begin
      rv_r <= v_r[NW-1];
    end
    if (en) begin
      quot_r <= {1'b0, q_r[NW-1]} + (NW+1)'(rnd);
      rsb_r  <= sb_r[NW-1];
    end
  end

  assign out_v  = rv_r;
  assign quot   = quot_r;
  assign out_sb = rsb_r;
endmodule

@@ rtl/core/qrs_back.sv @@
// Output stage: saturation of the rounded quotients and assembly of the
// result item into the output register. Uses qrs_pkg for the item types.
module qrs_back #(
  parameter int WORD_BITS = qrs_pkg::WORD_BITS,
  parameter int Q_BITS    = 51
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  logic [Q_BITS-1:0]  qx,
  input  logic [Q_BITS-1:0]  qy,
  input  qrs_pkg::qrs_kind_t kind,
  input  logic               sx,
  input  logic               sy,
  output logic               out_v,
  output qrs_pkg::qrs_out_t  out_item
);
  localparam int W  = WORD_BITS;
  localparam int OW = qrs_pkg::WORD_BITS;

  function automatic logic [W:0] clip(input logic neg, input logic [Q_BITS-1:0] mag);
    logic [Q_BITS-1:0] limit, v;
    logic              hit;
    limit = (Q_BITS'(1) << (W - 1)) - Q_BITS'(!neg);
    hit   = (mag > limit);
    v     = hit ? limit : mag;
    clip  = {hit, neg ? W'(~v + 1'b1) : v[W-1:0]};
  endfunction

  logic              v_r;
  qrs_pkg::qrs_out_t item_r, item_nxt;
  logic [W:0]        cx, cy, cyn;

  assign cx  = clip(sx, qx);
  assign cy  = clip(sy, qy);
  assign cyn = clip(!sy, qy);

  always_comb begin
    item_nxt           = '0;
    item_nxt.root_kind = kind;
    case (kind)
      qrs_pkg::KIND_REAL: begin
        item_nxt.root0_re  = OW'(signed'(cx[W-1:0]));
        item_nxt.root1_re  = OW'(signed'(cy[W-1:0]));
        item_nxt.saturated = cx[W] | cy[W];
      end
      qrs_pkg::KIND_CPLX: begin
        item_nxt.root0_re  = OW'(signed'(cx[W-1:0]));
        item_nxt.root1_re  = OW'(signed'(cx[W-1:0]));
        item_nxt.root0_im  = OW'(signed'(cy[W-1:0]));
        item_nxt.root1_im  = OW'(signed'(cyn[W-1:0]));
        item_nxt.saturated = cx[W] | cy[W] | cyn[W];
      end
      qrs_pkg::KIND_DOUBLE: begin
        item_nxt.root0_re  = OW'(signed'(cx[W-1:0]));
        item_nxt.root1_re  = OW'(signed'(cx[W-1:0]));
        item_nxt.saturated = cx[W];
      end
      default: begin
        item_nxt.root_kind = qrs_pkg::KIND_LEADZ;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_v    = v_r;
  assign out_item = item_r;
endmodule

@@ tb/quadratic_root_solver_test.sv @@
// Self-checking testbench for quadratic_root_solver: random and directed
// coefficient sets, each predicted in full width and compared field by field.
// Depends on qrs_pkg and the quadratic_root_solver RTL.
module quadratic_root_solver_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_BITS = qrs_pkg::WORD_BITS;
  localparam int FRAC_BITS = qrs_pkg::FRAC_BITS;
  localparam int LATENCY = 2 * WORD_BITS + FRAC_BITS + 9;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [63:0] HALF_MAG = 64'd1 << (WORD_BITS - 1);

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  qrs_pkg::qrs_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  qrs_pkg::qrs_out_t out_data;

  qrs_pkg::qrs_in_t  coeff_queue[$];
  qrs_pkg::qrs_out_t roots_expected[$];
  int       fail_count;
  int       idle_cycles;
  bit       stim_done;
  int       send_gap;
  int       hold_cycles;
  bit       hold_requested;
  bit       in_taken;

  quadratic_root_solver DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Rounded quotient num/den, ties away from zero; zero divisor gives zero.
  function automatic logic [127:0] div_round(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    logic [127:0] rem;
    if (den == 0) return 128'd0;
    q = num / den;
    rem = num % den;
    if (rem >= den - rem) q = q + 1;
    return q;
  endfunction

  function automatic logic [WORD_BITS-1:0] clip_signed(bit neg, logic [127:0] mag,
                                                       inout bit sat);
    logic [127:0] bound;
    logic [63:0] v;
    bound = neg ? HALF_MAG : HALF_MAG - 1;
    v = mag[63:0];
    if (mag > bound) begin
      v = bound[63:0];
      sat = 1'b1;
    end
    return neg ? WORD_BITS'(-v) : WORD_BITS'(v);
  endfunction

  function automatic logic [127:0] isqrt_floor(logic [127:0] d);
    logic [127:0] r;
    logic [127:0] t;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= d) r = t;
    end
    return r;
  endfunction

  function automatic qrs_pkg::qrs_out_t solve_roots(qrs_pkg::qrs_in_t c_in);
    qrs_pkg::qrs_out_t res;
    bit an, bn, cn, sat, dneg, reneg, nneg;
    logic [127:0] ma, mb, mc, bb, ac4, dmag, two_a, s, re, im, n, r0, r1;
    an = c_in.lead_coeff[WORD_BITS-1];
    bn = c_in.lin_coeff[WORD_BITS-1];
    cn = c_in.const_coeff[WORD_BITS-1];
    ma = an ? 128'(-64'(c_in.lead_coeff)) & ((128'd1 << WORD_BITS) - 1)
            : 128'(c_in.lead_coeff);
    mb = bn ? 128'(-64'(c_in.lin_coeff)) & ((128'd1 << WORD_BITS) - 1)
            : 128'(c_in.lin_coeff);
    mc = cn ? 128'(-64'(c_in.const_coeff)) & ((128'd1 << WORD_BITS) - 1)
            : 128'(c_in.const_coeff);
    res = '0;
    sat = 1'b0;
    if (ma == 0) begin
      res.root_kind = qrs_pkg::KIND_LEADZ;
      return res;
    end
    bb = mb * mb;
    ac4 = (ma * mc) << 2;
    dneg = 1'b0;
    if (an != cn) dmag = bb + ac4;
    else if (bb >= ac4) dmag = bb - ac4;
    else begin
      dneg = 1'b1;
      dmag = ac4 - bb;
    end
    two_a = ma << 1;
    if (dneg || dmag == 0) begin
      re = div_round(mb << FRAC_BITS, two_a);
      reneg = (mb != 0) && (bn == an);
      res.root0_re = clip_signed(reneg, re, sat);
      res.root1_re = clip_signed(reneg, re, sat);
      if (dneg) begin
        s = isqrt_floor(dmag);
        im = div_round(s << FRAC_BITS, two_a);
        res.root0_im = clip_signed(an, im, sat);
        res.root1_im = clip_signed(!an, im, sat);
        res.root_kind = qrs_pkg::KIND_CPLX;
      end else begin
        res.root_kind = qrs_pkg::KIND_DOUBLE;
      end
    end else begin
      s = isqrt_floor(dmag);
      n = mb + s;
      nneg = !bn && (mb != 0);
      r0 = div_round(n << FRAC_BITS, two_a);
      r1 = div_round((mc << 1) << FRAC_BITS, n);
      res.root0_re = clip_signed(nneg != an, r0, sat);
      res.root1_re = clip_signed((mc != 0) && (cn != nneg), r1, sat);
      res.root_kind = qrs_pkg::KIND_REAL;
    end
    res.saturated = sat;
    return res;
  endfunction

  // The input handshake is judged at the rising edge where it takes effect.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // Driver: the predictor runs for the item taken at the last rising edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        roots_expected.push_back(solve_roots(in_data));
        void'(coeff_queue.pop_front());
        send_gap = pick_gap();
      end
      if (!in_valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (coeff_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= coeff_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off while items keep coming.
  int stall_left;
  always @(negedge clk) begin
    if (hold_requested && hold_cycles < 300) begin
      hold_cycles++;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= (stall_left > 0);
    end
  end

  // Monitor: compare against the oldest expected result.
  always @(posedge clk) begin
    qrs_pkg::qrs_out_t exp_r;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (roots_expected.size() == 0) begin
          $error("result with no pending item: %p", out_data);
          fail_count++;
        end else begin
          exp_r = roots_expected.pop_front();
          if (out_data.root0_re !== exp_r.root0_re) begin
            $error("root0_re expected %0d got %0d", exp_r.root0_re, out_data.root0_re);
            fail_count++;
          end
          if (out_data.root0_im !== exp_r.root0_im) begin
            $error("root0_im expected %0d got %0d", exp_r.root0_im, out_data.root0_im);
            fail_count++;
          end
          if (out_data.root1_re !== exp_r.root1_re) begin
            $error("root1_re expected %0d got %0d", exp_r.root1_re, out_data.root1_re);
            fail_count++;
          end
          if (out_data.root1_im !== exp_r.root1_im) begin
            $error("root1_im expected %0d got %0d", exp_r.root1_im, out_data.root1_im);
            fail_count++;
          end
          if (out_data.root_kind !== exp_r.root_kind) begin
            $error("root_kind expected %0d got %0d", exp_r.root_kind, out_data.root_kind);
            fail_count++;
          end
          if (out_data.saturated !== exp_r.saturated) begin
            $error("saturated expected %0d got %0d", exp_r.saturated, out_data.saturated);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("quadratic_root_solver_test NOT OK");
        $finish;
      end
    end
  end

  function automatic logic [WORD_BITS-1:0] rand_coeff();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return WORD_BITS'($signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS));
      2: return WORD_BITS'($signed($urandom_range(0, 512)) - 256) << FRAC_BITS;
      3: return WORD_BITS'($signed($urandom_range(0, 64)) - 32);
      4: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, {(WORD_BITS - 1){1'b0}}}
                | WORD_BITS'($urandom_range(0, 3));
      default: return 0;
    endcase
  endfunction

  task automatic add_item(logic [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] b,
                          logic [WORD_BITS-1:0] c);
    qrs_pkg::qrs_in_t it;
    it.lead_coeff = a;
    it.lin_coeff = b;
    it.const_coeff = c;
    coeff_queue.push_back(it);
  endtask

  localparam logic [WORD_BITS-1:0] ONE = 1 << FRAC_BITS;
  localparam logic [WORD_BITS-1:0] MAXV = {1'b0, {(WORD_BITS - 1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MINV = {1'b1, {(WORD_BITS - 1){1'b0}}};

  initial begin
    logic [WORD_BITS-1:0] r, a, b, c;
    fail_count = 0;
    idle_cycles = 0;
    send_gap = 0;
    stall_left = 0;
    hold_cycles = 0;
    hold_requested = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    rst_n = 1'b0;
    // Directed: leading zero, double root, complex pair, real roots with b
    // zero, negative a, and extreme coefficients that saturate.
    add_item(0, ONE, ONE);
    add_item(ONE, -2 * ONE, ONE);
    add_item(ONE, 0, ONE);
    add_item(-ONE, 0, ONE);
    add_item(ONE, 0, -4 * ONE);
    add_item(ONE, 3 * ONE, 2 * ONE);
    add_item(-ONE, 3 * ONE, -2 * ONE);
    add_item(2 * ONE, -5 * ONE, 0);
    add_item(1, MAXV, 1);
    add_item(1, MINV, 1);
    add_item(1, 0, MAXV);
    add_item(-1, 0, MAXV);
    add_item(MAXV, MAXV, MAXV);
    add_item(MINV, MINV, MINV);
    add_item(MINV, MAXV, MINV);
    add_item(MAXV, 0, MINV);
    add_item(1, 1, 1);
    add_item(-1, 2, -1);
    add_item(MINV, 0, 0);
    add_item(ONE, MINV, MAXV);
    for (int i = 0; i < 1400; i++) begin
      r = $urandom_range(0, 9);
      a = rand_coeff();
      b = rand_coeff();
      c = rand_coeff();
      // Some double roots: b = 2k, a = 1, c = k^2 with exact units.
      if (r == 0) begin
        a = ONE;
        b = WORD_BITS'($signed($urandom_range(0, 200)) - 100) << (FRAC_BITS + 1);
        c = WORD_BITS'(($signed(b) >>> (FRAC_BITS + 1)) * ($signed(b) >>> (FRAC_BITS + 1)))
            << FRAC_BITS;
      end
      add_item(a, b, c);
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (coeff_queue.size() < 1200);
    hold_requested = 1'b1;
    wait (coeff_queue.size() == 0 && !in_valid);
    wait (roots_expected.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("quadratic_root_solver_test OK");
    else $display("quadratic_root_solver_test NOT OK");
    $finish;
  end

endmodule
